FILE: src/lse_pkg.sv
// Shared types and constants for the bitmap LSB header extractor.
package lse_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_MLEN   = 3'd2,
    PH_MCHAR  = 3'd3,
    PH_XLEN   = 3'd4,
    PH_XCHAR  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MAGIC = 2'd0,
    KIND_EXTN  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MAGIC_LEN = 2'd1,
    ERR_MISMATCH  = 2'd2,
    ERR_EXTN_LEN  = 2'd3
  } err_t;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_MAGIC     = 1'b0;
  localparam logic CFG_EXPECTED_MAGIC_LEN = 1'b1;

  localparam int MAGIC_W   = 64;
  localparam int MLEN_W    = 4;
  localparam int MAX_CHARS = 8;

  // Result queue between parser and output side
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    err_t       error_code;
    logic       section_end;
  } result_t;

endpackage

FILE: src/lsb_stego_header_extractor.sv
// Top level of the bitmap LSB header extractor: config registers, parser and result queue.
//
// Takes one bitmap file byte per transaction and recovers the string hidden in the
// byte LSBs: after a HEADER_BYTES-byte header, 32 bits of magic length
// (1..MAGIC_LIMIT-1), the magic characters at 8 bytes each (checked against
// expected_magic, first char in the top byte, expected_magic_length chars, at most 8),
// then 32 bits of extension length (1..EXTN_LIMIT-1) and the extension characters.
// Each decoded character is one result transaction; a bad length or a magic mismatch
// gives one error transaction (with section_end set) in place of any further output,
// and the block ignores bytes until the next in_frame_start. in_frame_start restarts
// parsing from any state. Rate: one byte per clock, sustained; each accepted byte updates
// the parser state. Results pass through a 4-entry queue, so in_stall rises only when
// that queue is full because out_stall has been holding off results. Each result is
// written into the queue and reaches out_* from the queue head.
// Config writes are taken at any edge with cfg_we high; write them only while idle.
module lsb_stego_header_extractor
  import lse_pkg::*;
#(
  parameter int HEADER_BYTES = 54,
  parameter int MAGIC_LIMIT  = 50,
  parameter int EXTN_LIMIT   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [MAGIC_W-1:0] cfg_wdata,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_image_byte,
  input  logic               in_frame_start,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_char_value,
  output logic [1:0]         out_error_code,
  output logic               out_section_end
);

  logic [MAGIC_W-1:0] expected_magic_r;
  logic [MLEN_W-1:0]  expected_magic_length_r;

  logic    in_accept;
  logic    q_full;
  logic    res_valid;
  result_t res;
  result_t head;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_magic_r        <= '0;
      expected_magic_length_r <= MLEN_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_EXPECTED_MAGIC) expected_magic_r <= cfg_wdata;
      if (cfg_index == CFG_EXPECTED_MAGIC_LEN) begin
        expected_magic_length_r <= cfg_wdata[MLEN_W-1:0];
      end
    end
  end

  // at most one result per byte, so a free queue slot is enough to take a byte
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  lse_parser #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAGIC_LIMIT  (MAGIC_LIMIT),
    .EXTN_LIMIT   (EXTN_LIMIT)
  ) u_parser (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .byte_accept           (in_accept),
    .image_byte            (in_image_byte),
    .frame_start           (in_frame_start),
    .expected_magic        (expected_magic_r),
    .expected_magic_length (expected_magic_length_r),
    .res_valid             (res_valid),
    .res                   (res)
  );

  lse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .full       (q_full),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head_data  (head)
  );

  assign out_result_kind = head.kind;
  assign out_char_value  = head.char_value;
  assign out_error_code  = head.error_code;
  assign out_section_end = head.section_end;

`ifndef SYNTHESIS
  // results only come out of accepted bytes
  a_res_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_accept)
    else $error("result without accepted byte");

  // a result leaves the queue in the cycle after it was produced at the earliest
  a_out_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("output valid without prior result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty queue");
`endif

endmodule

FILE: src/lse_parser.sv
// Front end: byte parser state machine that classifies bytes and produces result transactions.
module lse_parser
  import lse_pkg::*;
#(
  parameter int HEADER_BYTES = 54,
  parameter int MAGIC_LIMIT  = 50,
  parameter int EXTN_LIMIT   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_accept,
  input  logic [7:0]         image_byte,
  input  logic               frame_start,
  input  logic [MAGIC_W-1:0] expected_magic,
  input  logic [MLEN_W-1:0]  expected_magic_length,
  output logic               res_valid,
  output result_t            res
);

  localparam logic [5:0]  HDR_LAST  = 6'(HEADER_BYTES);
  localparam logic [31:0] MLIMIT_32 = 32'(MAGIC_LIMIT);
  localparam logic [31:0] XLIMIT_32 = 32'(EXTN_LIMIT);

  phase_t      phase_r, phase_nxt;
  logic [5:0]  byte_count_r, byte_count_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  sec_len_r, sec_len_nxt;
  logic [5:0]  char_idx_r, char_idx_nxt;
  logic        mism_r, mism_nxt;

  // frame start restarts the parse with this byte as first header byte
  phase_t      ph_eff;
  logic [5:0]  bc_base, idx_base, len_base;
  logic [31:0] acc_base;
  logic        mism_base;

  logic [5:0]  bc_inc, idx_inc;
  logic [31:0] acc_sh, len_limit;
  logic [7:0]  ch, want;
  logic [3:0]  exp_len;
  logic        hdr_done, len_done, char_done, len_bad, last_char;
  logic        mism_char, mism_upd, magic_fail;

  assign ph_eff    = frame_start ? PH_HEADER : phase_r;
  assign bc_base   = frame_start ? 6'd0 : byte_count_r;
  assign acc_base  = frame_start ? 32'd0 : acc_r;
  assign idx_base  = frame_start ? 6'd0 : char_idx_r;
  assign len_base  = frame_start ? 6'd0 : sec_len_r;
  assign mism_base = frame_start ? 1'b0 : mism_r;

  assign bc_inc    = bc_base + 6'd1;
  assign idx_inc   = idx_base + 6'd1;
  assign acc_sh    = {acc_base[30:0], image_byte[0]};
  assign ch        = acc_sh[7:0];

  assign hdr_done  = (bc_inc >= HDR_LAST);
  assign len_done  = bc_inc[5];              // 32 bits gathered
  assign char_done = (bc_inc >= 6'd8);
  assign len_limit = (ph_eff == PH_MLEN) ? MLIMIT_32 : XLIMIT_32;
  assign len_bad   = (acc_sh == 32'd0) || (acc_sh >= len_limit);
  assign last_char = (idx_inc >= len_base);

  assign exp_len   = (expected_magic_length > 4'(MAX_CHARS)) ? 4'(MAX_CHARS)
                                                             : expected_magic_length;
  // first expected character sits in the top byte
  assign want      = expected_magic[{~idx_base[2:0], 3'b000} +: 8];
  assign mism_char = (idx_base < {2'b00, exp_len}) ? (want != ch) : 1'b1;
  assign mism_upd  = mism_base | mism_char;
  assign magic_fail = mism_upd || (len_base != {2'b00, exp_len});

  // next phase
  always_comb begin
    phase_nxt = ph_eff;
    unique case (ph_eff)
      PH_IDLE:   phase_nxt = PH_IDLE;
      PH_HEADER: if (hdr_done) phase_nxt = PH_MLEN;
      PH_MLEN: begin
        if (len_done) phase_nxt = len_bad ? PH_IDLE : PH_MCHAR;
      end
      PH_XLEN: begin
        if (len_done) phase_nxt = len_bad ? PH_IDLE : PH_XCHAR;
      end
      PH_MCHAR: begin
        if (char_done && last_char) phase_nxt = magic_fail ? PH_IDLE : PH_XLEN;
      end
      PH_XCHAR: begin
        if (char_done && last_char) phase_nxt = PH_IDLE;
      end
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    byte_count_nxt = bc_base;
    acc_nxt        = acc_base;
    sec_len_nxt    = len_base;
    char_idx_nxt   = idx_base;
    mism_nxt       = mism_base;
    res_valid      = 1'b0;
    res            = '{kind: KIND_MAGIC, char_value: 8'd0,
                       error_code: ERR_NONE, section_end: 1'b0};
    unique case (ph_eff)
      PH_IDLE: ;
      PH_HEADER: begin
        if (hdr_done) begin
          byte_count_nxt = 6'd0;
          acc_nxt        = 32'd0;
        end else begin
          byte_count_nxt = bc_inc;
        end
      end
      PH_MLEN, PH_XLEN: begin
        byte_count_nxt = bc_inc;
        acc_nxt        = acc_sh;
        if (len_done) begin
          byte_count_nxt = 6'd0;
          acc_nxt        = 32'd0;
          if (len_bad) begin
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_code  = (ph_eff == PH_MLEN) ? ERR_MAGIC_LEN : ERR_EXTN_LEN;
            res.section_end = 1'b1;
          end else begin
            sec_len_nxt  = acc_sh[5:0];
            char_idx_nxt = 6'd0;
            mism_nxt     = 1'b0;
          end
        end
      end
      PH_MCHAR: begin
        byte_count_nxt = bc_inc;
        acc_nxt        = acc_sh;
        if (char_done) begin
          byte_count_nxt = 6'd0;
          acc_nxt        = 32'd0;
          char_idx_nxt   = idx_inc;
          mism_nxt       = mism_upd;
          res_valid      = 1'b1;
          if (last_char && magic_fail) begin
            res.kind        = KIND_ERROR;
            res.error_code  = ERR_MISMATCH;
            res.section_end = 1'b1;
          end else begin
            res.kind        = KIND_MAGIC;
            res.char_value  = ch;
            res.section_end = last_char;
          end
        end
      end
      PH_XCHAR: begin
        byte_count_nxt = bc_inc;
        acc_nxt        = acc_sh;
        if (char_done) begin
          byte_count_nxt  = 6'd0;
          acc_nxt         = 32'd0;
          char_idx_nxt    = idx_inc;
          res_valid       = 1'b1;
          res.kind        = KIND_EXTN;
          res.char_value  = ch;
          res.section_end = last_char;
        end
      end
      default: ;
    endcase
    if (!byte_accept) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_count_r <= 6'd0;
      acc_r        <= 32'd0;
      sec_len_r    <= 6'd0;
      char_idx_r   <= 6'd0;
      mism_r       <= 1'b0;
    end else if (byte_accept) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      acc_r        <= acc_nxt;
      sec_len_r    <= sec_len_nxt;
      char_idx_r   <= char_idx_nxt;
      mism_r       <= mism_nxt;
    end
  end

`ifndef SYNTHESIS
  // an error report always ends the frame
  a_err_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.kind == KIND_ERROR) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after error report");

  // idle and no restart: byte produces nothing
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) && !frame_start |-> !res_valid)
    else $error("result while idle");

  // error reports carry no character; characters carry no error
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ((res.kind == KIND_ERROR) ? (res.char_value == 8'd0 && res.section_end)
                                             : (res.error_code == ERR_NONE)))
    else $error("inconsistent result fields");
`endif

endmodule

FILE: src/lse_queue.sv
// Back end: small result queue whose head drives the output channel.
module lse_queue
  import lse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    head_valid,
  input  logic    head_stall,
  output result_t head_data
);

  result_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                pop, do_push;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign pop        = head_valid && !head_stall;
  assign do_push    = push && !full;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !pop) count_nxt = count_r + 1'b1;
    else if (!do_push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: verif/tb_lsb_stego_header_extractor.sv
// Self-checking testbench for lsb_stego_header_extractor: directed frames, then random frames.
module tb_lsb_stego_header_extractor;
  import lse_pkg::*;

  localparam int HEADER_BYTES = 54;
  localparam int MAGIC_LIMIT  = 50;
  localparam int EXTN_LIMIT   = 8;

  localparam int TOTAL_ITEMS  = 1350;  // byte transactions to offer over the whole run
  localparam int TAIL_CYCLES  = 8;     // tail wait after the last result, sized for the 4-entry result queue
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the result queue
  localparam int STALL_LIMIT  = 2000;  // watchdog: cycles with no transaction at all

  localparam logic [63:0] TXT_HIDE = "LSBHIDE!";
  localparam logic [63:0] TXT_EXT  = 64'h626D_70FF_007F_8001;
  localparam logic [63:0] ONES     = '1;
  localparam logic [31:0] LEN_NEG  = 32'h8000_0000;
  localparam int          GOOD_SZ  = HEADER_BYTES + 32 + 64 + 32 + 56;  // 8 magic, 7 ext chars

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_image_byte;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_char_value;
  logic [1:0]  out_error_code;
  logic        out_section_end;

  always #4 clk = ~clk;

  lsb_stego_header_extractor #(
    .HEADER_BYTES(HEADER_BYTES),
    .MAGIC_LIMIT (MAGIC_LIMIT),
    .EXTN_LIMIT  (EXTN_LIMIT)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_image_byte  (in_image_byte),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_char_value (out_char_value),
    .out_error_code (out_error_code),
    .out_section_end(out_section_end)
  );

  // ---------------------------------------------------------------------------
  // Parser model. Own copy of the config registers and the parse state, stepped
  // once per accepted byte transaction.
  // ---------------------------------------------------------------------------
  logic [63:0] want_magic = '0;
  logic [3:0]  want_len   = 4'd1;

  phase_t      p_phase    = PH_IDLE;
  logic [5:0]  p_count    = '0;
  logic [31:0] p_bits     = '0;
  logic [5:0]  p_sec_len  = '0;
  logic [5:0]  p_char_idx = '0;
  logic        p_mismatch = 1'b0;

  // Returns 1 when the byte produces a result transaction, placed in r.
  function automatic bit parse_byte(input logic [7:0] b, input logic fs, output result_t r);
    logic [31:0] lim;
    logic [7:0]  ch;
    logic [3:0]  n;
    logic        last;
    err_t        code;
    r = '{KIND_MAGIC, 8'h00, ERR_NONE, 1'b0};
    n = (want_len > 4'd8) ? 4'd8 : want_len;  // length 0 means an empty string
    if (fs) begin
      p_phase    = PH_HEADER;
      p_count    = '0;
      p_bits     = '0;
      p_sec_len  = '0;
      p_char_idx = '0;
      p_mismatch = 1'b0;
    end
    if (p_phase == PH_IDLE)
      return 1'b0;
    if (p_phase == PH_HEADER) begin
      p_count = p_count + 6'd1;
      if (p_count >= HEADER_BYTES) begin
        p_phase = PH_MLEN;
        p_count = '0;
        p_bits  = '0;
      end
      return 1'b0;
    end

    p_bits  = {p_bits[30:0], b[0]};
    p_count = p_count + 6'd1;

    if (p_phase == PH_MLEN || p_phase == PH_XLEN) begin
      if (p_count < 32)
        return 1'b0;
      lim = (p_phase == PH_MLEN) ? MAGIC_LIMIT : EXTN_LIMIT;
      // zero, negative and too-large lengths all fail here
      if (p_bits == 0 || p_bits >= lim) begin
        code    = (p_phase == PH_MLEN) ? ERR_MAGIC_LEN : ERR_EXTN_LEN;
        r       = '{KIND_ERROR, 8'h00, code, 1'b1};
        p_phase = PH_IDLE;
        p_count = '0;
        p_bits  = '0;
        return 1'b1;
      end
      p_sec_len  = p_bits[5:0];
      p_char_idx = '0;
      p_mismatch = 1'b0;
      p_phase    = (p_phase == PH_MLEN) ? PH_MCHAR : PH_XCHAR;
      p_count    = '0;
      p_bits     = '0;
      return 1'b0;
    end

    if (p_phase != PH_MCHAR && p_phase != PH_XCHAR) begin
      p_phase = PH_IDLE;
      return 1'b0;
    end
    if (p_count < 8)
      return 1'b0;
    ch = p_bits[7:0];
    if (p_phase == PH_MCHAR) begin
      if (p_char_idx >= n)
        p_mismatch = 1'b1;
      else if (8'(want_magic >> (8 * (7 - int'(p_char_idx)))) != ch)
        p_mismatch = 1'b1;
    end
    p_char_idx = p_char_idx + 6'd1;
    p_count    = '0;
    p_bits     = '0;
    last       = (p_char_idx >= p_sec_len);

    if (p_phase == PH_MCHAR) begin
      if (!last) begin
        r = '{KIND_MAGIC, ch, ERR_NONE, 1'b0};
        return 1'b1;
      end
      // final magic char is replaced by the error when the string differs
      if (p_mismatch || p_sec_len != n) begin
        r       = '{KIND_ERROR, 8'h00, ERR_MISMATCH, 1'b1};
        p_phase = PH_IDLE;
        return 1'b1;
      end
      p_phase = PH_XLEN;
      r = '{KIND_MAGIC, ch, ERR_NONE, 1'b1};
      return 1'b1;
    end
    if (last)
      p_phase = PH_IDLE;
    r = '{KIND_EXTN, ch, ERR_NONE, last};
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  result_t pending_results[$];
  bit      typed_frame = 1'b0;  // expectations come from the directed table, not the model
  int      mismatches  = 0;
  int      idle_cycles = 0;
  bit      hold_req    = 1'b0;

  // Every accepted byte steps the model; results queue up in order.
  always @(posedge clk) begin
    result_t r;
    bit      got;
    if (rst_n && in_valid && !in_stall) begin
      got = parse_byte(in_image_byte, in_frame_start, r);
      if (got && !typed_frame)
        pending_results.push_back(r);
    end
  end

  task automatic report(input string field, input logic [7:0] want_v, input logic [7:0] got_v);
    mismatches++;
    if (mismatches <= 50)
      $error("%s mismatch: expected %0h, got %0h", field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $error("result with none expected: kind %0d char %0h err %0d end %0b",
                 out_result_kind, out_char_value, out_error_code, out_section_end);
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind)
          report("result_kind", 8'(want.kind), 8'(out_result_kind));
        if (out_char_value !== want.char_value)
          report("char_value", want.char_value, out_char_value);
        if (out_error_code !== want.error_code)
          report("error_code", 8'(want.error_code), 8'(out_error_code));
        if (out_section_end !== want.section_end)
          report("section_end", 8'(want.section_end), 8'(out_section_end));
      end
    end
  end

  // Watchdog: a long run with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changes stall style after each random-length span; on request it holds
  // off for HOLD_CYCLES so the result queue fills and in_stall rises.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    int tick;
    out_stall <= 1'b0;
    tick = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;                          // free flowing
          1: out_stall <= ($urandom_range(0, 2) == 0);   // light random
          2: out_stall <= (tick % 4 == 1);               // periodic
          default: out_stall <= ($urandom_range(0, 5) != 0);  // heavy
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: byte transactions go out in bursts of random length with gaps.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] b;
    logic       fs;
  } byte_item_t;

  byte_item_t file_bytes[$];
  int         n_items    = 0;
  int         burst_left = 0;

  task automatic put_byte(input logic [7:0] b, input logic fs);
    file_bytes.push_back('{b, fs});
    n_items++;
  endtask

  // Hidden bits go MSB first, one per byte LSB; upper bits are random filler.
  task automatic put_bits(input logic [31:0] v, input int nbits);
    for (int k = nbits - 1; k >= 0; k--)
      put_byte({7'($urandom), v[k]}, 1'b0);
  endtask

  // One file: header, magic length, magic chars, extension length, extension chars.
  // Sections past an invalid length are left out; cut > 0 truncates the file.
  task automatic build_file(input logic [31:0] mlen, input logic [63:0] mtext,
                            input logic [31:0] xlen, input logic [63:0] xtext, input int cut);
    int start;
    start = file_bytes.size();
    put_byte(8'($urandom), 1'b1);
    repeat (HEADER_BYTES - 1) put_byte(8'($urandom), 1'b0);
    put_bits(mlen, 32);
    if (mlen != 0 && mlen < MAGIC_LIMIT) begin
      for (int i = 0; i < mlen; i++)
        put_bits((i < 8) ? 32'(mtext[63 - 8 * i -: 8]) : $urandom, 8);
      put_bits(xlen, 32);
      if (xlen != 0 && xlen < EXTN_LIMIT)
        for (int i = 0; i < xlen; i++)
          put_bits(32'(xtext[63 - 8 * i -: 8]), 8);
    end
    if (cut > 0)
      while (file_bytes.size() > start + cut) begin
        void'(file_bytes.pop_back());
        n_items--;
      end
  endtask

  task automatic put_noise(input int count);
    for (int k = 0; k < count; k++)
      put_byte((k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom), 1'b0);
  endtask

  task automatic send_item(input byte_item_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_image_byte  <= s.b;
    in_frame_start <= s.fs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_file();
    while (file_bytes.size() != 0)
      send_item(file_bytes.pop_front());
  endtask

  // Quiet the input and wait until every expected result is out, plus the
  // pipeline tail for bytes that make no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called once the block is idle.
  task automatic write_config(input logic [63:0] magic, input logic [3:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= CFG_EXPECTED_MAGIC_LEN;
    cfg_wdata <= 64'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    want_magic = magic;
    want_len   = len;
  endtask

  // ---------------------------------------------------------------------------
  // Directed frames. typed rows carry their expected result (t_err, or no
  // result at all for ERR_NONE); the rest are checked against the model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic        cfg;        // rewrite both registers first
    logic [63:0] cfg_magic;
    logic [3:0]  cfg_len;
    logic [15:0] noise;      // > 0: just this many bytes, no frame start
    logic [31:0] mlen;
    logic [63:0] mtext;
    logic [31:0] xlen;
    logic [63:0] xtext;
    logic [15:0] cut;        // > 0: file cut short after this many bytes
    logic        typed;
    err_t        t_err;
  } dir_row_t;

  dir_row_t dir_rows [0:9] = '{
    // bytes while idle right after reset: ignored
    '{1'b0, 64'h0, 4'd0, 16'd8, 32'd0, 64'h0, 32'd0, 64'h0, 16'd0, 1'b1, ERR_NONE},
    // reset config: a single NUL magic char matches
    '{1'b0, 64'h0, 4'd0, 16'd0, 32'd1, 64'h0, 32'd1, ONES, 16'd0, 1'b0, ERR_NONE},
    // bad magic lengths: zero, limit, negative
    '{1'b0, 64'h0, 4'd0, 16'd0, 32'd0, 64'h0, 32'd1, 64'h0, 16'd0, 1'b1, ERR_MAGIC_LEN},
    '{1'b0, 64'h0, 4'd0, 16'd0, 32'(MAGIC_LIMIT), 64'h0, 32'd1, 64'h0, 16'd0, 1'b1,
      ERR_MAGIC_LEN},
    '{1'b0, 64'h0, 4'd0, 16'd0, LEN_NEG, 64'h0, 32'd1, 64'h0, 16'd0, 1'b1, ERR_MAGIC_LEN},
    // one-char magic, extension length at the limit
    '{1'b1, TXT_HIDE, 4'd1, 16'd0, 32'd1, TXT_HIDE, 32'(EXTN_LIMIT), TXT_EXT, 16'd0, 1'b0,
      ERR_NONE},
    // expected length above 8 acts as 8; full magic, longest extension
    '{1'b1, ONES, 4'd15, 16'd0, 32'd8, ONES, 32'd7, TXT_EXT, 16'd0, 1'b0, ERR_NONE},
    // one wrong char mid-string, file ends with the error
    '{1'b0, 64'h0, 4'd0, 16'd0, 32'd8, ONES ^ 64'h0000_0040_0000_0000, 32'd1, TXT_EXT,
      16'(HEADER_BYTES + 32 + 64), 1'b0, ERR_NONE},
    // file cut inside the magic; the next frame start restarts the parser
    '{1'b0, 64'h0, 4'd0, 16'd0, 32'd8, ONES, 32'd7, TXT_EXT, 16'(HEADER_BYTES + 40), 1'b0,
      ERR_NONE},
    // expected length zero: every magic mismatches
    '{1'b1, 64'h0, 4'd0, 16'd0, 32'd1, 64'h0, 32'd1, 64'h0, 16'd0, 1'b1, ERR_MISMATCH}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          pick;
    int          good_len;
    int          new_len;
    int          cut;
    int          frame_no;
    bit          pressure;
    logic [31:0] mlen;
    logic [31:0] xlen;
    logic [63:0] mtext;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_EXPECTED_MAGIC;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_image_byte  <= '0;
    in_frame_start <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      settle();
      typed_frame = dir_rows[i].typed;
      if (dir_rows[i].cfg)
        write_config(dir_rows[i].cfg_magic, dir_rows[i].cfg_len);
      if (dir_rows[i].typed && dir_rows[i].t_err != ERR_NONE)
        pending_results.push_back('{KIND_ERROR, 8'h00, dir_rows[i].t_err, 1'b1});
      if (dir_rows[i].noise > 0)
        put_noise(dir_rows[i].noise);
      else
        build_file(dir_rows[i].mlen, dir_rows[i].mtext, dir_rows[i].xlen,
                   dir_rows[i].xtext, dir_rows[i].cut);
      send_file();
    end
    settle();
    typed_frame = 1'b0;

    // Random files: mostly well-formed with the configured magic, the rest
    // corrupted chars, odd or bad lengths, truncated files and loose bytes.
    // The first one runs against the long receiver hold-off.
    frame_no = 0;
    while (n_items < TOTAL_ITEMS) begin
      pressure = (frame_no == 0);
      if (pressure || $urandom_range(0, 2) == 0) begin
        settle();
        if (pressure)
          new_len = 8;
        else if ($urandom_range(0, 4) != 0)
          new_len = $urandom_range(1, 8);
        else
          new_len = $urandom_range(0, 15);
        write_config({$urandom, $urandom}, 4'(new_len));
      end

      good_len = (want_len > 8) ? 8 : (want_len == 0) ? 1 : want_len;
      mlen     = good_len;
      mtext    = want_magic;
      xlen     = $urandom_range(1, EXTN_LIMIT - 1);
      cut      = 0;
      pick     = pressure ? 100 : $urandom_range(0, 99);

      if (pressure) begin
        // long ext so results pile up behind the receiver hold-off
        xlen     = EXTN_LIMIT - 1;
        hold_req = 1'b1;
      end else if (pick < 15) begin
        mtext[8 * $urandom_range(0, 7) +: 8] = 8'($urandom);
      end else if (pick < 23) begin
        mlen  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAGIC_LIMIT - 1)
                                            : $urandom_range(1, 10);
        mtext = {$urandom, $urandom};
      end else if (pick < 31) begin
        case ($urandom_range(0, 3))
          0: mlen = 0;
          1: mlen = $urandom_range(MAGIC_LIMIT, 63);
          2: mlen = $urandom | LEN_NEG;
          default: mlen = $urandom;
        endcase
      end else if (pick < 37) begin
        case ($urandom_range(0, 3))
          0: xlen = 0;
          1: xlen = $urandom_range(EXTN_LIMIT, 31);
          2: xlen = $urandom | LEN_NEG;
          default: xlen = $urandom;
        endcase
      end else if (pick < 42) begin
        cut = $urandom_range(1, GOOD_SZ);
      end

      if (pick >= 42 && pick < 46)
        put_noise($urandom_range(2, 30));
      else
        build_file(mlen, mtext, xlen, {$urandom, $urandom}, cut);
      send_file();
      frame_no++;
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
